// ----- hw/rtl/dzf_pkg.sv -----
// dzf_pkg: shared constants and types for the five-tap outlier dezinger
// no dependencies; imported by the interfaces, dzf_merge and the top level

package dzf_pkg;

    // fixed field widths
    localparam int DATA_W    = 16;
    localparam int THR_W     = 16;
    localparam int THR_SQ_W  = 2 * THR_W;
    // the threshold is Q8.8, so its square carries sixteen fraction bits
    localparam int FRAC_BITS = 16;
    localparam int TAPS      = 5;
    localparam int NEIGHBOURS = 4;

    // flag value reported for a replaced sample in flag mode
    localparam logic [DATA_W-1:0] FLAG_HIT = 16'd50000;

    // register map
    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_MODE      = 1'b1
    } t_reg_idx;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_FLAG  = 1'b1
    } t_out_mode;

    // stage enables for the merge pipeline
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
    } t_pipe_ctl;

endpackage

// ----- hw/rtl/dzf_if.sv -----
// dzf_if: valid/ready channels for pixel requests and filtered results
// depends on dzf_pkg for field widths

interface dzf_pix_if;
    import dzf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample_before_two;
    logic [DATA_W-1:0] sample_before_one;
    logic [DATA_W-1:0] sample_center;
    logic [DATA_W-1:0] sample_after_one;
    logic [DATA_W-1:0] sample_after_two;

    modport source (
        output valid, sample_before_two, sample_before_one, sample_center,
               sample_after_one, sample_after_two,
        input  ready
    );
    modport sink (
        input  valid, sample_before_two, sample_before_one, sample_center,
               sample_after_one, sample_after_two,
        output ready
    );
endinterface

interface dzf_res_if;
    import dzf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              replaced;

    modport source (output valid, result_value, replaced, input ready);
    modport sink (input valid, result_value, replaced, output ready);
endinterface

// ----- hw/rtl/dzf_lane.sv -----
// dzf_lane: one lane of the deviation stage, squares |sum - 4*x|
// depends on nothing but its parameter; instanced five times by the top level

module dzf_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [SAMPLE_BITS+1:0]      i_sum,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    output logic [2*SAMPLE_BITS+3:0]    o_sq
);
    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int SQ_W  = 2 * SUM_W;

    logic [SUM_W-1:0] x4;
    logic [SUM_W-1:0] diff;
    logic [SQ_W-1:0]  n_sq;
    logic [SQ_W-1:0]  r_sq;

    // absolute difference between the neighbour sum and four times the sample
    assign x4   = {i_sample, 2'b00};
    assign diff = (i_sum >= x4) ? (i_sum - x4) : (x4 - i_sum);
    assign n_sq = SQ_W'(diff) * SQ_W'(diff);

    // registered square
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

// ----- hw/rtl/dzf_merge.sv -----
// dzf_merge: combines the lane squares, scales by the threshold and decides
// depends on dzf_pkg; fed by the dzf_lane instances in the top level

module dzf_merge #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  dzf_pkg::t_pipe_ctl                     i_ctl,
    input  logic [2*SAMPLE_BITS+3:0]               i_nb_sq [dzf_pkg::NEIGHBOURS],
    input  logic [2*SAMPLE_BITS+3:0]               i_ctr_sq,
    input  logic [SAMPLE_BITS-1:0]                 i_mean,
    input  logic [SAMPLE_BITS-1:0]                 i_centre,
    input  logic [dzf_pkg::THR_SQ_W-1:0]           i_thr_sq,
    input  logic                                   i_mode,
    output logic [dzf_pkg::DATA_W-1:0]             o_value,
    output logic                                   o_replaced
);
    import dzf_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int S_W    = SQ_W + 2;
    localparam int LHS_W  = SQ_W + 2;
    localparam int SHI_W  = S_W - FRAC_BITS;
    localparam int PHI_W  = THR_SQ_W + SHI_W;
    localparam int PLO_W  = THR_SQ_W + FRAC_BITS;
    localparam int RHS_W  = PHI_W + 1;
    localparam int CMP_W  = (RHS_W > LHS_W) ? RHS_W : LHS_W;

    // stage 3: spread sum and three times the squared centre deviation
    logic [S_W-1:0]         r_s;
    logic [LHS_W-1:0]       r_lhs3;
    logic [SAMPLE_BITS-1:0] r_mean3;
    logic [SAMPLE_BITS-1:0] r_ctr3;
    logic [S_W-1:0]         n_s;
    logic [LHS_W-1:0]       n_lhs;

    assign n_s = S_W'(i_nb_sq[0]) + S_W'(i_nb_sq[1])
               + S_W'(i_nb_sq[2]) + S_W'(i_nb_sq[3]);
    assign n_lhs = LHS_W'({i_ctr_sq, 1'b0}) + LHS_W'(i_ctr_sq);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_s     <= n_s;
            r_lhs3  <= n_lhs;
            r_mean3 <= i_mean;
            r_ctr3  <= i_centre;
        end
    end

    // stage 4: threshold square times the high and low parts of the spread
    logic [PHI_W-1:0]       r_phi;
    logic [PLO_W-1:0]       r_plo;
    logic [LHS_W-1:0]       r_lhs4;
    logic [SAMPLE_BITS-1:0] r_mean4;
    logic [SAMPLE_BITS-1:0] r_ctr4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_phi   <= PHI_W'(i_thr_sq) * PHI_W'(r_s[S_W-1:FRAC_BITS]);
            r_plo   <= PLO_W'(i_thr_sq) * PLO_W'(r_s[FRAC_BITS-1:0]);
            r_lhs4  <= r_lhs3;
            r_mean4 <= r_mean3;
            r_ctr4  <= r_ctr3;
        end
    end

    // stage 5: floor(thr^2 * S / 2^16) against 3*D^2, then pick the output
    logic [RHS_W-1:0]  rhs;
    logic              hit;
    logic [DATA_W-1:0] n_value;
    logic [DATA_W-1:0] r_value;
    logic              r_replaced;

    assign rhs = RHS_W'(r_phi) + RHS_W'(r_plo[PLO_W-1:FRAC_BITS]);
    assign hit = CMP_W'(r_lhs4) > CMP_W'(rhs);

    always_comb begin
        if (i_mode == MODE_FLAG) begin
            n_value = hit ? FLAG_HIT : '0;
        end else begin
            n_value = hit ? DATA_W'(r_mean4) : DATA_W'(r_ctr4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en5) begin
            r_value    <= n_value;
            r_replaced <= hit;
        end
    end

    assign o_value    = r_value;
    assign o_replaced = r_replaced;

endmodule

// ----- hw/rtl/five_tap_outlier_dezinger.sv -----
// five_tap_outlier_dezinger: top level, pipeline control, register port
// depends on dzf_pkg, dzf_if, dzf_lane and dzf_merge

// One pixel position across five slices enters per request and one result
// leaves per request, at a sustained rate of one per clock while o_res.ready
// stays high. The pipeline has five register stages (input and neighbour sum,
// five parallel squaring lanes, spread sum, threshold multiply, and compare
// with output select), and a result is offered from the last of them. Each
// stage holds its request only while the stage after it is full and stalled,
// so bubbles close up under back-pressure. The threshold (Q8.8) is at offset
// 0x0 and the output mode at 0x4; write them while no request is in flight.

module five_tap_outlier_dezinger #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dzf_pix_if.sink     i_pix,
    dzf_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dzf_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int SQ_W  = 2 * SUM_W;

    // configuration registers
    logic [THR_W-1:0]    r_thr;
    logic                r_mode;
    logic [THR_SQ_W-1:0] r_thr_sq;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_mode <= MODE_PIXEL;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THRESHOLD: begin
                    r_thr <= pwdata[THR_W-1:0];
                end
                REG_MODE: begin
                    r_mode <= pwdata[0];
                end
                default: begin
                    r_thr <= r_thr;
                end
            endcase
        end
    end

    // squared threshold, settled well before a request reaches the multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq <= '0;
        end else begin
            r_thr_sq <= THR_SQ_W'(r_thr) * THR_SQ_W'(r_thr);
        end
    end

    // register read-back
    always_comb begin
        case (cfg_idx)
            REG_THRESHOLD: prdata = 32'(r_thr);
            REG_MODE:      prdata = 32'(r_mode);
            default:       prdata = '0;
        endcase
    end

    // pipeline valid bits and stage enables
    logic [5:1] r_vld;
    logic [5:1] en;
    t_pipe_ctl  ctl;

    assign en[5] = !r_vld[5] || o_res.ready;
    assign en[4] = !r_vld[4] || en[5];
    assign en[3] = !r_vld[3] || en[4];
    assign en[2] = !r_vld[2] || en[3];
    assign en[1] = !r_vld[1] || en[2];

    assign i_pix.ready = en[1];
    assign ctl.en3 = en[3];
    assign ctl.en4 = en[4];
    assign ctl.en5 = en[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_pix.valid;
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
            if (en[5]) r_vld[5] <= r_vld[4];
        end
    end

    // stage 1: masked samples and neighbour sum
    logic [SAMPLE_BITS-1:0] r_smp [TAPS];
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;

    assign n_sum = SUM_W'(i_pix.sample_before_two[SAMPLE_BITS-1:0])
                 + SUM_W'(i_pix.sample_before_one[SAMPLE_BITS-1:0])
                 + SUM_W'(i_pix.sample_after_one[SAMPLE_BITS-1:0])
                 + SUM_W'(i_pix.sample_after_two[SAMPLE_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_smp[0] <= i_pix.sample_before_two[SAMPLE_BITS-1:0];
            r_smp[1] <= i_pix.sample_before_one[SAMPLE_BITS-1:0];
            r_smp[2] <= i_pix.sample_center[SAMPLE_BITS-1:0];
            r_smp[3] <= i_pix.sample_after_one[SAMPLE_BITS-1:0];
            r_smp[4] <= i_pix.sample_after_two[SAMPLE_BITS-1:0];
            r_sum    <= n_sum;
        end
    end

    // stage 2: one squaring lane per tap, centre lane gives D^2
    logic [SQ_W-1:0]        lane_sq [TAPS];
    logic [SQ_W-1:0]        nb_sq   [NEIGHBOURS];
    logic [SAMPLE_BITS-1:0] r_mean2;
    logic [SAMPLE_BITS-1:0] r_ctr2;

    for (genvar g = 0; g < TAPS; g++) begin : g_lane
        dzf_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (en[2]),
            .i_sum    (r_sum),
            .i_sample (r_smp[g]),
            .o_sq     (lane_sq[g])
        );
    end

    assign nb_sq[0] = lane_sq[0];
    assign nb_sq[1] = lane_sq[1];
    assign nb_sq[2] = lane_sq[3];
    assign nb_sq[3] = lane_sq[4];

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_mean2 <= r_sum[SUM_W-1:2];
            r_ctr2  <= r_smp[2];
        end
    end

    // stages 3 to 5: merge and decide
    dzf_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_nb_sq    (nb_sq),
        .i_ctr_sq   (lane_sq[2]),
        .i_mean     (r_mean2),
        .i_centre   (r_ctr2),
        .i_thr_sq   (r_thr_sq),
        .i_mode     (r_mode),
        .o_value    (o_res.result_value),
        .o_replaced (o_res.replaced)
    );

    assign o_res.valid = r_vld[5];

endmodule
